// ===== rtl/mdns_qnf_pkg.sv =====
// ----------------------------------------------------------------------------
// mdns_qnf_pkg
// Types and constants shared by the mDNS query name filter.
// ----------------------------------------------------------------------------
`default_nettype none

package mdns_qnf_pkg;

    localparam int MAX_HOST_BYTES   = 16;
    localparam int MAX_SUFFIX_BYTES = 8;

    localparam logic [5:0] HOST_LEN_MAX   = 6'(MAX_HOST_BYTES);
    localparam logic [5:0] SUFFIX_LEN_MAX = 6'(MAX_SUFFIX_BYTES);

    // Configuration register indexes.
    localparam logic [2:0] CFG_HOST_LEN      = 3'd0;
    localparam logic [2:0] CFG_HOST_BYTES_LO = 3'd1;
    localparam logic [2:0] CFG_HOST_BYTES_HI = 3'd2;
    localparam logic [2:0] CFG_SUFFIX_LEN    = 3'd3;
    localparam logic [2:0] CFG_SUFFIX_BYTES  = 3'd4;

    localparam logic [4:0]  HOST_LEN_RESET     = 5'd0;
    localparam logic [3:0]  SUFFIX_LEN_RESET   = 4'd5;
    localparam logic [63:0] SUFFIX_BYTES_RESET = 64'h0000_006C_6163_6F6C;

    // Header byte 2 holds QR, opcode, AA, TC and RD; any of QR, opcode or TC
    // set means the packet is skipped.
    localparam logic [7:0]  FLAGS_IGNORE_MASK = 8'hfa;
    localparam logic [7:0]  COMPRESSION_MASK  = 8'hc0;
    localparam logic [3:0]  HEADER_LAST       = 4'd11;
    localparam logic [3:0]  HEADER_FLAGS_POS  = 4'd2;
    localparam logic [3:0]  HEADER_QD_HI_POS  = 4'd4;
    localparam logic [3:0]  HEADER_QD_LO_POS  = 4'd5;

    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [15:0] TYPE_AAAA      = 16'd28;
    localparam logic [15:0] CLASS_IN       = 16'h0001;
    localparam logic [15:0] CLASS_IN_FLUSH = 16'h8001;

    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN    = 3'd1,
        PH_BODY   = 3'd2,
        PH_SKIP   = 3'd3,
        PH_TAIL   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        VERDICT_IGNORE    = 2'd0,
        VERDICT_RESPOND   = 2'd1,
        VERDICT_MALFORMED = 2'd2,
        VERDICT_NONE      = 2'd3
    } verdict_t;

endpackage

`default_nettype wire

// ===== rtl/mdns_query_name_filter_top.sv =====
// ----------------------------------------------------------------------------
// mdns_query_name_filter_top
// Byte-wide mDNS question filter that decides whether a query asks for us.
//
// Input channel: one packet byte per word (data_byte, last_byte) with
// in_valid/in_stall. Output channel: one verdict word per packet on
// out_valid/out_stall, given for the packet's last byte only: ignore,
// respond or malformed.
// A byte is taken every cycle while in_stall is low; the per-byte parse is a
// single pass of constant-depth logic between the input register and the state
// and result registers. The last byte's verdict passes from the input register
// into the result register. While the receiver stalls, non-final bytes keep
// flowing; only a last byte that finds the result register full and stalled
// waits in the input register, and in_stall rises until the verdict drains.
// The configuration port writes host and suffix labels and their lengths; the
// user must write it only while no packet is in progress; nothing enforces it.
// Reset clears the parser to the start of a header and loads the default
// suffix label "local" with an empty host label.
// ----------------------------------------------------------------------------
`default_nettype none

module mdns_query_name_filter_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_write,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       verdict
);

    // Configuration registers.
    logic [4:0]  host_len_reg;
    logic [63:0] host_lo_reg;
    logic [63:0] host_hi_reg;
    logic [3:0]  suffix_len_reg;
    logic [63:0] suffix_reg;

    // Input register.
    logic        s1_valid_reg;
    logic [7:0]  s1_byte_reg;
    logic        s1_last_reg;
    logic        s1_go;

    // Output register.
    logic        out_valid_reg;
    logic [1:0]  verdict_reg;

    // Parser state.
    mdns_qnf_pkg::phase_t   phase_reg, phase_next;
    logic [3:0]  header_count_reg, header_count_next;
    logic [7:0]  flags_high_reg, flags_high_next;
    logic [15:0] questions_left_reg, questions_left_next;
    logic [1:0]  label_number_reg, label_number_next;
    logic [5:0]  label_left_reg, label_left_next;
    logic [5:0]  label_pos_reg, label_pos_next;
    logic        name_ok_reg, name_ok_next;
    logic [1:0]  tail_count_reg, tail_count_next;
    logic [23:0] tail_shift_reg, tail_shift_next;
    logic        respond_reg, respond_next;
    mdns_qnf_pkg::verdict_t early_reg, early_next;
    mdns_qnf_pkg::verdict_t final_verdict;

    logic [127:0] host_all;
    logic [7:0]   want_byte;
    logic [5:0]   left_dec;
    logic [15:0]  q_dec;
    logic [15:0]  tail_type;
    logic [15:0]  tail_class;
    logic         tail_ok;
    logic         resp_now;

    // A last byte waits only when its verdict has nowhere to go.
    assign s1_go    = s1_valid_reg && !(s1_last_reg && out_valid_reg && out_stall);
    assign in_stall = s1_valid_reg && !s1_go;

    assign out_valid = out_valid_reg;
    assign verdict   = verdict_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            host_len_reg   <= mdns_qnf_pkg::HOST_LEN_RESET;
            host_lo_reg    <= '0;
            host_hi_reg    <= '0;
            suffix_len_reg <= mdns_qnf_pkg::SUFFIX_LEN_RESET;
            suffix_reg     <= mdns_qnf_pkg::SUFFIX_BYTES_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mdns_qnf_pkg::CFG_HOST_LEN:      host_len_reg   <= cfg_data[4:0];
                mdns_qnf_pkg::CFG_HOST_BYTES_LO: host_lo_reg    <= cfg_data;
                mdns_qnf_pkg::CFG_HOST_BYTES_HI: host_hi_reg    <= cfg_data;
                mdns_qnf_pkg::CFG_SUFFIX_LEN:    suffix_len_reg <= cfg_data[3:0];
                mdns_qnf_pkg::CFG_SUFFIX_BYTES:  suffix_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_byte_reg <= data_byte;
            s1_last_reg <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_last_reg)
        begin
            verdict_reg <= final_verdict;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= mdns_qnf_pkg::PH_HEADER;
            header_count_reg   <= '0;
            flags_high_reg     <= '0;
            questions_left_reg <= '0;
            label_number_reg   <= '0;
            label_left_reg     <= '0;
            label_pos_reg      <= '0;
            name_ok_reg        <= 1'b1;
            tail_count_reg     <= '0;
            tail_shift_reg     <= '0;
            respond_reg        <= 1'b0;
            early_reg          <= mdns_qnf_pkg::VERDICT_NONE;
        end
        else if (s1_go)
        begin
            phase_reg          <= phase_next;
            header_count_reg   <= header_count_next;
            flags_high_reg     <= flags_high_next;
            questions_left_reg <= questions_left_next;
            label_number_reg   <= label_number_next;
            label_left_reg     <= label_left_next;
            label_pos_reg      <= label_pos_next;
            name_ok_reg        <= name_ok_next;
            tail_count_reg     <= tail_count_next;
            tail_shift_reg     <= tail_shift_next;
            respond_reg        <= respond_next;
            early_reg          <= early_next;
        end
    end

    assign host_all   = {host_hi_reg, host_lo_reg};
    assign left_dec   = label_left_reg - 6'd1;
    assign q_dec      = questions_left_reg - 16'd1;
    assign tail_type  = tail_shift_reg[23:8];
    assign tail_class = {tail_shift_reg[7:0], s1_byte_reg};
    assign tail_ok    = name_ok_reg &&
                        (tail_type == mdns_qnf_pkg::TYPE_A ||
                         tail_type == mdns_qnf_pkg::TYPE_AAAA) &&
                        (tail_class == mdns_qnf_pkg::CLASS_IN ||
                         tail_class == mdns_qnf_pkg::CLASS_IN_FLUSH);
    assign resp_now   = respond_reg || tail_ok;

    // Expected label byte; positions past the stored label read as zero.
    always_comb
    begin
        want_byte = 8'h00;
        if (label_number_reg == 2'd0)
        begin
            if (label_pos_reg[5:4] == 2'b00)
            begin
                want_byte = host_all[{label_pos_reg[3:0], 3'b000} +: 8];
            end
        end
        else if (label_pos_reg[5:3] == 3'b000)
        begin
            want_byte = suffix_reg[{label_pos_reg[2:0], 3'b000} +: 8];
        end
    end

    always_comb
    begin
        phase_next          = phase_reg;
        header_count_next   = header_count_reg;
        flags_high_next     = flags_high_reg;
        questions_left_next = questions_left_reg;
        label_number_next   = label_number_reg;
        label_left_next     = label_left_reg;
        label_pos_next      = label_pos_reg;
        name_ok_next        = name_ok_reg;
        tail_count_next     = tail_count_reg;
        tail_shift_next     = tail_shift_reg;
        respond_next        = respond_reg;
        early_next          = early_reg;

        case (phase_reg)
            mdns_qnf_pkg::PH_HEADER:
            begin
                if (header_count_reg == mdns_qnf_pkg::HEADER_FLAGS_POS)
                begin
                    flags_high_next = s1_byte_reg;
                end
                else if (header_count_reg == mdns_qnf_pkg::HEADER_QD_HI_POS)
                begin
                    questions_left_next = {s1_byte_reg, 8'h00};
                end
                else if (header_count_reg == mdns_qnf_pkg::HEADER_QD_LO_POS)
                begin
                    questions_left_next = {questions_left_reg[15:8], s1_byte_reg};
                end

                if (header_count_reg >= mdns_qnf_pkg::HEADER_LAST)
                begin
                    if ((flags_high_reg & mdns_qnf_pkg::FLAGS_IGNORE_MASK) != 8'h00 ||
                        questions_left_reg == 16'd0)
                    begin
                        phase_next = mdns_qnf_pkg::PH_DONE;
                        early_next = mdns_qnf_pkg::VERDICT_IGNORE;
                    end
                    else
                    begin
                        phase_next        = mdns_qnf_pkg::PH_LEN;
                        label_number_next = '0;
                        label_left_next   = '0;
                        label_pos_next    = '0;
                        name_ok_next      = 1'b1;
                        tail_count_next   = '0;
                        tail_shift_next   = '0;
                    end
                end
                else
                begin
                    header_count_next = header_count_reg + 4'd1;
                end
            end

            mdns_qnf_pkg::PH_LEN:
            begin
                if (s1_byte_reg == 8'h00)
                begin
                    if (label_number_reg != 2'd2)
                    begin
                        name_ok_next = 1'b0;
                    end
                    phase_next = mdns_qnf_pkg::PH_TAIL;
                end
                else if ((s1_byte_reg & mdns_qnf_pkg::COMPRESSION_MASK) != 8'h00)
                begin
                    name_ok_next = 1'b0;
                    phase_next   = mdns_qnf_pkg::PH_SKIP;
                end
                else
                begin
                    if (label_number_reg == 2'd0)
                    begin
                        if ({1'b0, host_len_reg} > mdns_qnf_pkg::HOST_LEN_MAX ||
                            s1_byte_reg != {3'b000, host_len_reg})
                        begin
                            name_ok_next = 1'b0;
                        end
                    end
                    else if (label_number_reg == 2'd1)
                    begin
                        if ({2'b00, suffix_len_reg} > mdns_qnf_pkg::SUFFIX_LEN_MAX ||
                            s1_byte_reg != {4'b0000, suffix_len_reg})
                        begin
                            name_ok_next = 1'b0;
                        end
                    end
                    else
                    begin
                        name_ok_next = 1'b0;
                    end
                    label_left_next = s1_byte_reg[5:0];
                    label_pos_next  = '0;
                    phase_next      = mdns_qnf_pkg::PH_BODY;
                end
            end

            mdns_qnf_pkg::PH_BODY:
            begin
                if (name_ok_reg &&
                    (label_number_reg == 2'd2 || want_byte != s1_byte_reg))
                begin
                    name_ok_next = 1'b0;
                end
                label_pos_next  = label_pos_reg + 6'd1;
                label_left_next = left_dec;
                if (left_dec == 6'd0)
                begin
                    if (label_number_reg != 2'd2)
                    begin
                        label_number_next = label_number_reg + 2'd1;
                    end
                    phase_next = mdns_qnf_pkg::PH_LEN;
                end
            end

            mdns_qnf_pkg::PH_SKIP:
            begin
                phase_next = mdns_qnf_pkg::PH_TAIL;
            end

            mdns_qnf_pkg::PH_TAIL:
            begin
                if (tail_count_reg != 2'd3)
                begin
                    tail_shift_next = {tail_shift_reg[15:0], s1_byte_reg};
                    tail_count_next = tail_count_reg + 2'd1;
                end
                else
                begin
                    respond_next        = resp_now;
                    questions_left_next = q_dec;
                    if (q_dec == 16'd0)
                    begin
                        phase_next = mdns_qnf_pkg::PH_DONE;
                        early_next = resp_now ? mdns_qnf_pkg::VERDICT_RESPOND
                                              : mdns_qnf_pkg::VERDICT_IGNORE;
                    end
                    else
                    begin
                        phase_next        = mdns_qnf_pkg::PH_LEN;
                        label_number_next = '0;
                        label_left_next   = '0;
                        label_pos_next    = '0;
                        name_ok_next      = 1'b1;
                        tail_count_next   = '0;
                        tail_shift_next   = '0;
                    end
                end
            end

            default:
            begin
            end
        endcase

        // An undecided packet at its last byte is cut short.
        final_verdict = (early_next == mdns_qnf_pkg::VERDICT_NONE)
                      ? mdns_qnf_pkg::VERDICT_MALFORMED : early_next;

        if (s1_last_reg)
        begin
            phase_next          = mdns_qnf_pkg::PH_HEADER;
            header_count_next   = '0;
            flags_high_next     = '0;
            questions_left_next = '0;
            label_number_next   = '0;
            label_left_next     = '0;
            label_pos_next      = '0;
            name_ok_next        = 1'b1;
            tail_count_next     = '0;
            tail_shift_next     = '0;
            respond_next        = 1'b0;
            early_next          = mdns_qnf_pkg::VERDICT_NONE;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb_mdns_query_name_filter_top.sv =====
// ----------------------------------------------------------------------------
// tb_mdns_query_name_filter_top
// Self-checking bench for the mDNS question name filter. Packets are built
// byte by byte, pushed through the input channel with random gaps and checked
// against a local parser that predicts the verdict of every packet. Directed
// tests cover headers, question shapes and label settings at their limits.
// A long receiver hold-off and seeded random traffic over several label
// settings follow.
// ----------------------------------------------------------------------------

module tb_mdns_query_name_filter_top;

    timeunit 1ns;
    timeprecision 1ps;

    import mdns_qnf_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 7;
    localparam int SETTLE_CYCLES   = 4;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_BYTES    = 400;
    localparam int RANDOM_PACKETS  = 60;

    localparam logic [63:0] PRINTER_LABEL = 64'h0072_6574_6e69_7270;

    typedef enum int {
        QN_MATCH        = 0,
        QN_BAD_BYTE     = 1,
        QN_BAD_LEN      = 2,
        QN_ONE_LABEL    = 3,
        QN_THREE_LABELS = 4,
        QN_POINTER      = 5,
        QN_ROOT         = 6,
        QN_RANDOM       = 7
    } qname_kind_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_write = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = '0;
    logic        last_byte = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  verdict;

    mdns_query_name_filter_top u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Label settings as the filter holds them.
    logic [4:0]  cfg_host_len     = HOST_LEN_RESET;
    logic [63:0] cfg_host_lo      = '0;
    logic [63:0] cfg_host_hi      = '0;
    logic [3:0]  cfg_suffix_len   = SUFFIX_LEN_RESET;
    logic [63:0] cfg_suffix_bytes = SUFFIX_BYTES_RESET;

    // Parser state of the packet in progress.
    phase_t      ph;
    logic [3:0]  hdr_cnt;
    logic [7:0]  flags_hi;
    logic [15:0] q_left;
    logic [1:0]  lbl_num;
    logic [5:0]  lbl_left;
    logic [5:0]  lbl_pos;
    logic        name_match;
    logic [1:0]  tail_cnt;
    logic [23:0] tail_sr;
    logic        resp;
    verdict_t    decided;

    verdict_t    verdicts_due[$];
    logic [7:0]  pkt[$];

    int  send_idle_pct  = 32;
    int  recv_stall_pct = 32;
    bit  hold_off_req   = 1'b0;
    int  mismatches     = 0;
    int  bytes_sent     = 0;
    int  packets_sent   = 0;
    int  settings_used  = 0;
    int  quiet_cycles   = 0;
    int  seen_respond   = 0;
    int  seen_ignore    = 0;
    int  seen_malformed = 0;

    function automatic logic [7:0] host_label_byte(logic [5:0] i);
        if (i < 6'd8)
            return 8'(cfg_host_lo >> (8 * i));
        if (i < 6'd16)
            return 8'(cfg_host_hi >> (8 * (i - 6'd8)));
        return 8'h00;
    endfunction

    function automatic logic [7:0] suffix_label_byte(logic [5:0] i);
        if (i < 6'd8)
            return 8'(cfg_suffix_bytes >> (8 * i));
        return 8'h00;
    endfunction

    function automatic void begin_question();
        ph         = PH_LEN;
        lbl_num    = '0;
        lbl_left   = '0;
        lbl_pos    = '0;
        name_match = 1'b1;
        tail_cnt   = '0;
        tail_sr    = '0;
    endfunction

    function automatic void reset_packet_state();
        begin_question();
        ph       = PH_HEADER;
        hdr_cnt  = '0;
        flags_hi = '0;
        q_left   = '0;
        resp     = 1'b0;
        decided  = VERDICT_NONE;
    endfunction

    function automatic void close_packet(verdict_t v);
        ph      = PH_DONE;
        decided = v;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [63:0] val);
        case (idx)
            CFG_HOST_LEN:      cfg_host_len     = val[4:0];
            CFG_HOST_BYTES_LO: cfg_host_lo      = val;
            CFG_HOST_BYTES_HI: cfg_host_hi      = val;
            CFG_SUFFIX_LEN:    cfg_suffix_len   = val[3:0];
            CFG_SUFFIX_BYTES:  cfg_suffix_bytes = val;
            default: ;
        endcase
    endfunction

    // Advances the parser by one accepted byte; a last byte yields a verdict.
    function automatic void parse_byte(input logic [7:0] b, input logic is_last,
                                       output bit has_verdict, output verdict_t v);
        logic [15:0] qtype;
        logic [15:0] qclass;
        logic [7:0]  want;
        has_verdict = 1'b0;
        v = VERDICT_NONE;
        case (ph)
            PH_HEADER:
            begin
                if (hdr_cnt == HEADER_FLAGS_POS)
                    flags_hi = b;
                else if (hdr_cnt == HEADER_QD_HI_POS)
                    q_left = {b, 8'h00};
                else if (hdr_cnt == HEADER_QD_LO_POS)
                    q_left = q_left | {8'h00, b};
                if (hdr_cnt >= HEADER_LAST)
                begin
                    if ((flags_hi & FLAGS_IGNORE_MASK) != 8'h00 || q_left == 16'h0000)
                        close_packet(VERDICT_IGNORE);
                    else
                        begin_question();
                end
                else
                    hdr_cnt = hdr_cnt + 4'd1;
            end
            PH_LEN:
            begin
                if (b == 8'h00)
                begin
                    if (lbl_num != 2'd2)
                        name_match = 1'b0;
                    ph = PH_TAIL;
                end
                else if ((b & COMPRESSION_MASK) != 8'h00)
                begin
                    name_match = 1'b0;
                    ph = PH_SKIP;
                end
                else
                begin
                    if (lbl_num == 2'd0)
                    begin
                        if (cfg_host_len > MAX_HOST_BYTES || b != {3'b000, cfg_host_len})
                            name_match = 1'b0;
                    end
                    else if (lbl_num == 2'd1)
                    begin
                        if (cfg_suffix_len > MAX_SUFFIX_BYTES || b != {4'b0000, cfg_suffix_len})
                            name_match = 1'b0;
                    end
                    else
                        name_match = 1'b0;
                    lbl_left = b[5:0];
                    lbl_pos  = '0;
                    ph       = PH_BODY;
                end
            end
            PH_BODY:
            begin
                if (name_match)
                begin
                    want = (lbl_num == 2'd0) ? host_label_byte(lbl_pos)
                                             : suffix_label_byte(lbl_pos);
                    if (lbl_num > 2'd1 || want != b)
                        name_match = 1'b0;
                end
                lbl_pos  = lbl_pos + 6'd1;
                lbl_left = lbl_left - 6'd1;
                if (lbl_left == 6'd0)
                begin
                    if (lbl_num < 2'd2)
                        lbl_num = lbl_num + 2'd1;
                    ph = PH_LEN;
                end
            end
            PH_SKIP:
                ph = PH_TAIL;
            PH_TAIL:
            begin
                if (tail_cnt < 2'd3)
                begin
                    tail_sr  = {tail_sr[15:0], b};
                    tail_cnt = tail_cnt + 2'd1;
                end
                else
                begin
                    qtype  = tail_sr[23:8];
                    qclass = {tail_sr[7:0], b};
                    if (name_match && (qtype == TYPE_A || qtype == TYPE_AAAA) &&
                        (qclass == CLASS_IN || qclass == CLASS_IN_FLUSH))
                        resp = 1'b1;
                    q_left = q_left - 16'd1;
                    if (q_left == 16'h0000)
                        close_packet(resp ? VERDICT_RESPOND : VERDICT_IGNORE);
                    else
                        begin_question();
                end
            end
            default: ;
        endcase
        if (is_last)
        begin
            has_verdict = 1'b1;
            v = (decided == VERDICT_NONE) ? VERDICT_MALFORMED : decided;
            reset_packet_state();
        end
    endfunction

    // ------------------------------------------------------------------
    // Packet construction
    // ------------------------------------------------------------------

    function automatic void put_header(logic [7:0] flags, logic [15:0] qd);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back(flags);
        pkt.push_back(8'($urandom));
        pkt.push_back(qd[15:8]);
        pkt.push_back(qd[7:0]);
        repeat (6) pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_host_label(logic [5:0] len, int bad_pos);
        logic [7:0] b;
        int i;
        pkt.push_back({2'b00, len});
        for (i = 0; i < int'(len); i++)
        begin
            b = host_label_byte(6'(i));
            if (i == bad_pos)
                b = b ^ 8'(1 << $urandom_range(7));
            pkt.push_back(b);
        end
    endfunction

    function automatic void put_suffix_label(int bad_pos);
        logic [7:0] b;
        int i;
        pkt.push_back({4'b0000, cfg_suffix_len});
        for (i = 0; i < int'(cfg_suffix_len); i++)
        begin
            b = suffix_label_byte(6'(i));
            if (i == bad_pos)
                b = b ^ 8'(1 << $urandom_range(7));
            pkt.push_back(b);
        end
    endfunction

    function automatic void put_pointer(logic [7:0] mark);
        pkt.push_back(mark);
        pkt.push_back(8'($urandom));
    endfunction

    function automatic void put_tail(logic [15:0] qtype, logic [15:0] qclass);
        pkt.push_back(qtype[15:8]);
        pkt.push_back(qtype[7:0]);
        pkt.push_back(qclass[15:8]);
        pkt.push_back(qclass[7:0]);
    endfunction

    function automatic void put_random_tail();
        logic [15:0] qt;
        logic [15:0] qc;
        qt = $urandom_range(1) ? TYPE_A : TYPE_AAAA;
        qc = $urandom_range(1) ? CLASS_IN : CLASS_IN_FLUSH;
        if ($urandom_range(99) >= 75)
        begin
            if ($urandom_range(1))
                qt = 16'($urandom);
            else
                qc = 16'($urandom);
        end
        put_tail(qt, qc);
    endfunction

    function automatic void put_name(qname_kind_t k);
        int n;
        int bad_pos;
        logic [5:0] len;
        if (k == QN_ROOT)
        begin
            pkt.push_back(8'h00);
            return;
        end
        if (k == QN_RANDOM)
        begin
            repeat ($urandom_range(1, 3))
            begin
                len = 6'($urandom_range(1, 8));
                pkt.push_back({2'b00, len});
                repeat (len) pkt.push_back(8'($urandom));
            end
            pkt.push_back(8'h00);
            return;
        end
        // A corrupted byte may land in either label body.
        n = int'(cfg_host_len) + int'(cfg_suffix_len);
        bad_pos = -1;
        if (k == QN_BAD_BYTE && n > 0)
            bad_pos = $urandom_range(n - 1);
        len = {1'b0, cfg_host_len};
        if (k == QN_BAD_LEN)
            len = (len > 6'd1 && $urandom_range(1)) ? len - 6'd1 : len + 6'd1;
        put_host_label(len, bad_pos);
        if (k == QN_ONE_LABEL)
        begin
            pkt.push_back(8'h00);
            return;
        end
        if (k == QN_POINTER)
        begin
            put_pointer(8'($urandom_range(8'h40, 8'hff)));
            return;
        end
        put_suffix_label(bad_pos - int'(cfg_host_len));
        if (k == QN_THREE_LABELS)
        begin
            len = 6'($urandom_range(1, 4));
            pkt.push_back({2'b00, len});
            repeat (len) pkt.push_back(8'($urandom));
        end
        pkt.push_back(8'h00);
    endfunction

    function automatic void cut_packet(int n);
        repeat (n) void'(pkt.pop_back());
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers and checker
    // ------------------------------------------------------------------

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        bit has_v;
        verdict_t v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b, is_last, has_v, v);
        if (has_v)
            verdicts_due.push_back(v);
        bytes_sent++;
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++)
            send_byte(pkt[i], i == pkt.size() - 1);
        pkt.delete();
        packets_sent++;
    endtask

    task automatic query_packet(qname_kind_t k, logic [15:0] qt, logic [15:0] qc);
        put_header(8'h00, 16'd1);
        put_name(k);
        put_tail(qt, qc);
        send_packet();
    endtask

    // Waits until every verdict is back and the pipeline has emptied.
    task automatic drain();
        in_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes all five registers plus the unused indexes, which must be ignored.
    task automatic load_labels(input logic [4:0] hl, input logic [63:0] lo,
                               input logic [63:0] hi, input logic [3:0] sl,
                               input logic [63:0] sb);
        logic [63:0] vals [8];
        int i;
        for (i = 0; i < 8; i++)
            vals[i] = {$urandom, $urandom};
        vals[CFG_HOST_LEN][4:0]   = hl;
        vals[CFG_HOST_BYTES_LO]   = lo;
        vals[CFG_HOST_BYTES_HI]   = hi;
        vals[CFG_SUFFIX_LEN][3:0] = sl;
        vals[CFG_SUFFIX_BYTES]    = sb;
        for (i = 0; i < 8; i++)
        begin
            cfg_write <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
            @(posedge clk);
            apply_reg(3'(i), vals[i]);
        end
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    initial
    begin : receiver
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                for (n = 0; n < HOLD_OFF_CYCLES; n++)
                    @(posedge clk);
                hold_off_req = 1'b0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        verdict_t exp_v;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (verdicts_due.size() == 0)
            begin
                $error("verdict word %0d arrived with no packet outstanding", verdict);
                mismatches++;
            end
            else
            begin
                exp_v = verdicts_due.pop_front();
                if (verdict !== exp_v)
                begin
                    $error("verdict: expected %0d, got %0d", exp_v, verdict);
                    mismatches++;
                end
                case (exp_v)
                    VERDICT_RESPOND: seen_respond++;
                    VERDICT_IGNORE:  seen_ignore++;
                    default:         seen_malformed++;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $error("no word moved on either channel for %0d cycles", STALL_LIMIT);
            $display("FAIL mdns_query_name_filter_top");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_defaults();
        // The host length resets to zero, so a query for x.local cannot match.
        put_header(8'h00, 16'd1);
        pkt.push_back(8'd1);
        pkt.push_back(8'h78);
        put_suffix_label(-1);
        pkt.push_back(8'h00);
        put_tail(TYPE_A, CLASS_IN);
        send_packet();
        pkt.push_back(8'hff);
        send_packet();
    endtask

    task automatic test_header_cases();
        logic [7:0] flag_set [4];
        int i;
        flag_set = '{8'h80, 8'h08, 8'h02, 8'h05};
        drain();
        load_labels(5'd7, PRINTER_LABEL, {$urandom, $urandom}, SUFFIX_LEN_RESET,
                    SUFFIX_BYTES_RESET);
        // Response, opcode and truncation bits each skip the packet; AA and RD do not.
        for (i = 0; i < 4; i++)
        begin
            put_header(flag_set[i], 16'd1);
            put_name(QN_MATCH);
            put_tail(TYPE_A, CLASS_IN);
            send_packet();
        end
        put_header(8'h00, 16'd0);
        repeat (3) pkt.push_back(8'($urandom));
        send_packet();
        put_header(8'h00, 16'd1);
        cut_packet(6);
        send_packet();
    endtask

    task automatic test_question_shapes();
        query_packet(QN_MATCH, TYPE_A, CLASS_IN);
        query_packet(QN_MATCH, TYPE_AAAA, CLASS_IN_FLUSH);
        query_packet(QN_MATCH, 16'h00ff, CLASS_IN);
        query_packet(QN_MATCH, TYPE_A, 16'h0003);
        query_packet(QN_BAD_BYTE, TYPE_A, CLASS_IN);
        query_packet(QN_BAD_LEN, TYPE_A, CLASS_IN);
        query_packet(QN_ONE_LABEL, TYPE_A, CLASS_IN);
        query_packet(QN_THREE_LABELS, TYPE_A, CLASS_IN);
        query_packet(QN_ROOT, TYPE_A, CLASS_IN);
        query_packet(QN_RANDOM, TYPE_AAAA, CLASS_IN);
        put_header(8'h00, 16'd1);
        put_pointer(8'hff);
        put_tail(TYPE_A, CLASS_IN);
        send_packet();
        // A compressed first question must not hide a matching second one.
        put_header(8'h00, 16'd2);
        put_pointer(8'h40);
        put_tail(TYPE_A, CLASS_IN);
        put_name(QN_MATCH);
        put_tail(TYPE_AAAA, CLASS_IN);
        send_packet();
        put_header(8'h00, 16'd1);
        put_name(QN_MATCH);
        put_tail(TYPE_A, CLASS_IN);
        pkt.push_back(8'h00);
        pkt.push_back(8'hff);
        pkt.push_back(8'hc0);
        send_packet();
        put_header(8'h00, 16'd1);
        put_pointer(8'hc0);
        cut_packet(1);
        send_packet();
        put_header(8'h00, 16'd1);
        put_name(QN_MATCH);
        put_tail(TYPE_A, CLASS_IN);
        cut_packet(1);
        send_packet();
        put_header(8'h00, 16'd2);
        put_name(QN_MATCH);
        put_tail(TYPE_A, CLASS_IN);
        send_packet();
    endtask

    task automatic test_config_extremes();
        logic [4:0] host_lens [6];
        logic [3:0] suffix_lens [6];
        int i;
        host_lens   = '{5'd16, 5'd1, 5'd17, 5'd31, 5'd16, 5'd0};
        suffix_lens = '{4'd8, 4'd1, 4'd8, 4'd15, 4'd9, 4'd0};
        for (i = 0; i < 6; i++)
        begin
            drain();
            load_labels(host_lens[i], {$urandom, $urandom}, {$urandom, $urandom},
                        suffix_lens[i], {$urandom, $urandom});
            query_packet(QN_MATCH, TYPE_A, CLASS_IN);
            query_packet(QN_BAD_BYTE, TYPE_AAAA, CLASS_IN_FLUSH);
        end
    endtask

    task automatic test_backpressure();
        drain();
        load_labels(5'd7, PRINTER_LABEL, {$urandom, $urandom}, SUFFIX_LEN_RESET,
                    SUFFIX_BYTES_RESET);
        // The receiver stops for a long stretch while packets keep coming, so
        // a second last byte finds the verdict register full.
        hold_off_req = 1'b1;
        repeat (8)
            query_packet($urandom_range(1) ? QN_MATCH : QN_ROOT, TYPE_A, CLASS_IN);
    endtask

    task automatic random_labels();
        logic [4:0] hl;
        logic [3:0] sl;
        int r;
        r = $urandom_range(99);
        if (r < 10)
            hl = 5'd16;
        else if (r < 20)
            hl = 5'd1;
        else if (r < 80)
            hl = 5'($urandom_range(1, 16));
        else if (r < 90)
            hl = 5'($urandom_range(17, 31));
        else
            hl = 5'd0;
        r = $urandom_range(99);
        if (r < 15)
            sl = 4'd8;
        else if (r < 25)
            sl = 4'd1;
        else if (r < 85)
            sl = 4'($urandom_range(1, 8));
        else if (r < 95)
            sl = 4'($urandom_range(9, 15));
        else
            sl = 4'd0;
        load_labels(hl, {$urandom, $urandom}, {$urandom, $urandom}, sl, {$urandom, $urandom});
    endtask

    task automatic random_packet();
        qname_kind_t k;
        logic [7:0] f;
        int nq;
        int r;
        r = $urandom_range(99);
        if (r < 70)
        begin
            nq = $urandom_range(1, 3);
            put_header(8'($urandom) & ~FLAGS_IGNORE_MASK, 16'(nq));
            repeat (nq)
            begin
                if ($urandom_range(99) < 50)
                    k = QN_MATCH;
                else
                    k = qname_kind_t'($urandom_range(int'(QN_BAD_BYTE), int'(QN_RANDOM)));
                put_name(k);
                put_random_tail();
            end
            if ($urandom_range(3) == 0)
                repeat ($urandom_range(1, 4)) pkt.push_back(8'($urandom));
            if ($urandom_range(9) == 0)
                cut_packet($urandom_range(1, pkt.size() - 1));
        end
        else if (r < 80)
        begin
            f = 8'($urandom);
            if ((f & FLAGS_IGNORE_MASK) == 8'h00)
                f = f | (8'h08 << $urandom_range(4));
            put_header(f, 16'($urandom_range(1, 3)));
            put_name(QN_MATCH);
            put_random_tail();
            if ($urandom_range(1))
                cut_packet($urandom_range(1, 6));
        end
        else if (r < 88)
        begin
            put_header(8'($urandom) & ~FLAGS_IGNORE_MASK, 16'd0);
            repeat ($urandom_range(0, 6)) pkt.push_back(8'($urandom));
        end
        else
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
        send_packet();
    endtask

    task automatic test_random_traffic();
        int bytes_at_start;
        int packets_at_start;
        int setting;
        bytes_at_start   = bytes_sent;
        packets_at_start = packets_sent;
        setting = 0;
        while (bytes_sent - bytes_at_start < RANDOM_BYTES ||
               packets_sent - packets_at_start < RANDOM_PACKETS)
        begin
            drain();
            random_labels();
            // One setting runs with both sides at full rate.
            if (setting == 2)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            else
            begin
                send_idle_pct  = 32;
                recv_stall_pct = 32;
            end
            repeat (12) random_packet();
            setting++;
        end
    endtask

    initial
    begin
        reset_packet_state();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_header_cases();
        test_question_shapes();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        drain();
        $display("Sent %0d packets (%0d bytes) over %0d label settings.",
                 packets_sent, bytes_sent, settings_used);
        $display("Verdicts checked: %0d respond, %0d ignore, %0d malformed; %0d mismatches.",
                 seen_respond, seen_ignore, seen_malformed, mismatches);
        if (mismatches == 0)
            $display("PASS mdns_query_name_filter_top");
        else
            $display("FAIL mdns_query_name_filter_top");
        $finish;
    end

endmodule
